// File: rtl/core/btmx_pkg.sv
`timescale 1ns / 1ps

package btmx_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [31:0] word;
    } t_item;

    typedef struct packed {
        logic [31:0] best_xor;
        logic [1:0]  status;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic leaf;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic skip;
        logic insert;
    } t_sts;

endpackage

// File: rtl/core/binary_trie_max_xor_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                      Transfer
// input     start, busy, i_item        taken at an edge with start high and busy low
// result    o_done, o_result           o_done high for one cycle, taken at its end
//
// An insert passes through a load step, a walk step for each trie level (a single
// node-table read per level chases the pointer), a leaf step that clears a freshly
// allocated leaf, and a result step. A query has no leaf step. A dropped insert or
// a query on an empty set goes from the load step straight to the result step.
// After reset the table is usable at once: nodes are cleared as they are
// allocated, so there is no clearing pass.
// busy stays high until the result cycle ends; the receiver cannot stall.

module binary_trie_max_xor_unit
    import btmx_pkg::*;
#(
    parameter int WIDTH     = 32,
    parameter int MAX_NODES = 8192
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    t_cmd cmd;
    t_sts sts;

    btmx_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    btmx_datapath #(
        .WIDTH     (WIDTH),
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

// File: rtl/core/btmx_ctrl.sv
`timescale 1ns / 1ps

module btmx_ctrl
    import btmx_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output logic o_done,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam int CW = $clog2(WIDTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_LEAF = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_count    = CW'(WIDTH);
                    n_state    = i_sts.skip ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                n_count    = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_state = i_sts.insert ? S_LEAF : S_DONE;
                end
            end
            S_LEAF: begin
                o_cmd.leaf = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

`ifndef ASSERT_OFF
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_count != '0))
        else $error("walk running with zero levels left");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> busy)
        else $error("accepted word did not make the unit busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");
`endif

endmodule

// File: rtl/core/btmx_datapath.sv
`timescale 1ns / 1ps

module btmx_datapath
    import btmx_pkg::*;
#(
    parameter int WIDTH     = 32,
    parameter int MAX_NODES = 8192
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    output t_result o_result
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int FW    = $clog2(MAX_NODES + 1);
    localparam int BW    = (WIDTH < 32) ? WIDTH : 32;
    localparam int LIMIT = MAX_NODES - WIDTH;

    // Each entry holds the child for bit one in the upper half, bit zero below.
    logic [2*NW-1:0] mem [MAX_NODES];

    logic [2*NW-1:0] r_rdata;
    logic            r_rd_zero;
    logic            r_root_written;
    logic [FW-1:0]   r_next_free, n_next_free;
    logic [NW-1:0]   r_node, n_node;
    logic [WIDTH-1:0] r_word, r_best;
    logic            r_op;
    logic            r_fresh, n_fresh;
    logic            r_stop, n_stop;
    logic [1:0]      r_status;

    logic [2*NW-1:0] entry, wdata, base;
    logic [NW-1:0]   rd_addr, c_same, c_other, alloc;
    logic            we, bit_in, b, full, empty;

    function automatic logic node_ok(input logic [NW-1:0] c);
        node_ok = (c != '0) && (FW'(c) < FW'(MAX_NODES));
    endfunction

    assign full  = r_next_free > FW'(LIMIT);
    assign empty = (r_next_free == FW'(1));

    assign o_sts.skip   = (i_item.operation == OP_INSERT) ? full : empty;
    assign o_sts.insert = (r_op == OP_INSERT);

    // The root is never cleared in the table, so it reads empty until written.
    assign entry   = r_rd_zero ? '0 : r_rdata;
    assign b       = r_word[WIDTH-1];
    assign c_same  = b ? entry[2*NW-1:NW] : entry[NW-1:0];
    assign c_other = b ? entry[NW-1:0] : entry[2*NW-1:NW];
    assign alloc   = r_next_free[NW-1:0];
    assign base    = r_fresh ? '0 : entry;

    always_comb begin
        n_node      = r_node;
        n_next_free = r_next_free;
        n_fresh     = r_fresh;
        n_stop      = r_stop;
        bit_in      = 1'b0;
        we          = 1'b0;
        wdata       = '0;
        rd_addr     = r_node;
        if (i_cmd.load) begin
            n_node  = '0;
            n_fresh = 1'b0;
            n_stop  = 1'b0;
            rd_addr = '0;
        end else if (i_cmd.step) begin
            if (r_op == OP_INSERT) begin
                if (!r_fresh && node_ok(c_same)) begin
                    n_node = c_same;
                end else begin
                    we          = 1'b1;
                    wdata       = b ? {alloc, base[NW-1:0]} : {base[2*NW-1:NW], alloc};
                    n_node      = alloc;
                    n_next_free = r_next_free + FW'(1);
                    n_fresh     = 1'b1;
                end
            end else if (!r_stop) begin
                if (node_ok(c_other)) begin
                    bit_in = 1'b1;
                    n_node = c_other;
                end else if (node_ok(c_same)) begin
                    n_node = c_same;
                end else begin
                    n_stop = 1'b1;
                end
            end
            rd_addr = n_node;
        end else if (i_cmd.leaf) begin
            we    = r_fresh;
            wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_node] <= wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free    <= FW'(1);
            r_root_written <= 1'b0;
            r_rd_zero      <= 1'b1;
            r_fresh        <= 1'b0;
            r_stop         <= 1'b0;
            r_node         <= '0;
        end else begin
            r_next_free <= n_next_free;
            r_fresh     <= n_fresh;
            r_stop      <= n_stop;
            r_node      <= n_node;
            r_rd_zero   <= (rd_addr == '0) && !r_root_written;
            if (we && (r_node == '0)) begin
                r_root_written <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item.operation;
            r_word <= WIDTH'(i_item.word);
            r_best <= '0;
            if (i_item.operation == OP_INSERT) begin
                r_status <= full ? ST_FULL : ST_OK;
            end else begin
                r_status <= empty ? ST_EMPTY : ST_OK;
            end
        end else if (i_cmd.step) begin
            r_word <= r_word << 1;
            r_best <= (r_best << 1) | WIDTH'(bit_in);
        end
    end

    assign o_result.best_xor = 32'(r_best[BW-1:0]);
    assign o_result.status   = r_status;

`ifndef ASSERT_OFF
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free != '0) && (r_next_free <= FW'(MAX_NODES)))
        else $error("node allocator out of range");
    a_alloc_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_next_free != r_next_free) |-> (i_cmd.step && (r_op == OP_INSERT)))
        else $error("node allocated outside an insert walk");
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && (i_item.operation == OP_INSERT) && full)
            |=> (r_status == ST_FULL))
        else $error("insert into a full pool not reported");
`endif

endmodule
